### sv/ctgs_pkg.sv
`timescale 1ns / 1ps

package ctgs_pkg;

    localparam int DISPLAY_COLUMNS = 128;
    localparam int CHAR_PITCH      = 6;
    localparam int MAX_TEXT_LENGTH = 21;

    localparam int CHAR_W   = 8;
    localparam int PAGE_W   = 4;
    localparam int LEN_W    = 5;
    localparam int BYTE_W   = 8;
    localparam int POS_W    = (MAX_TEXT_LENGTH > 2) ? $clog2(MAX_TEXT_LENGTH) : 1;
    localparam int CLAMP_W  = $clog2(MAX_TEXT_LENGTH + 1) + 1;
    localparam int SPAN_W   = $clog2(CHAR_PITCH * MAX_TEXT_LENGTH + DISPLAY_COLUMNS + 1) + 1;

    localparam int S_TDATA_W = 24;
    localparam int M_TDATA_W = 8;

    localparam int GLYPHS    = 59;
    localparam int GLYPH_W   = 6;
    localparam int GLYPH_COLS = 5;

    localparam logic [BYTE_W-1:0] CMD_PAGE   = 8'hB0;
    localparam logic [BYTE_W-1:0] CMD_COL_LO = 8'h00;
    localparam logic [BYTE_W-1:0] CMD_COL_HI = 8'h10;
    localparam logic [BYTE_W-1:0] BLANK_COL  = 8'h00;

    // Output byte slots within one character
    localparam int SLOT_W = 4;
    localparam logic [SLOT_W-1:0] SLOT_PAGE   = 4'd0;
    localparam logic [SLOT_W-1:0] SLOT_COL_LO = 4'd1;
    localparam logic [SLOT_W-1:0] SLOT_COL_HI = 4'd2;
    localparam logic [SLOT_W-1:0] SLOT_GLYPH0 = 4'd3;
    localparam logic [SLOT_W-1:0] SLOT_SPACER = 4'd8;

    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = 1;
    localparam int QCNT_W      = 2;

    typedef struct packed {
        logic [PAGE_W-1:0]  page;
        logic [BYTE_W-1:0]  column;
        logic [GLYPH_W-1:0] glyph;
    } ctgs_entry_t;

    typedef logic [BYTE_W-1:0] glyph_row_t [0:GLYPH_COLS-1];

    localparam glyph_row_t FONT_ROM [0:GLYPHS-1] = '{
        '{8'h00,8'h00,8'h00,8'h00,8'h00}, '{8'h00,8'h00,8'h5F,8'h00,8'h00},
        '{8'h00,8'h07,8'h00,8'h07,8'h00}, '{8'h14,8'h7F,8'h14,8'h7F,8'h14},
        '{8'h24,8'h2A,8'h7F,8'h2A,8'h12}, '{8'h23,8'h13,8'h08,8'h64,8'h62},
        '{8'h36,8'h49,8'h55,8'h22,8'h50}, '{8'h00,8'h05,8'h03,8'h00,8'h00},
        '{8'h00,8'h1C,8'h22,8'h41,8'h00}, '{8'h00,8'h41,8'h22,8'h1C,8'h00},
        '{8'h14,8'h08,8'h3E,8'h08,8'h14}, '{8'h08,8'h08,8'h3E,8'h08,8'h08},
        '{8'h00,8'h50,8'h30,8'h00,8'h00}, '{8'h08,8'h08,8'h08,8'h08,8'h08},
        '{8'h00,8'h60,8'h60,8'h00,8'h00}, '{8'h20,8'h10,8'h08,8'h04,8'h02},
        '{8'h3E,8'h51,8'h49,8'h45,8'h3E}, '{8'h00,8'h42,8'h7F,8'h40,8'h00},
        '{8'h42,8'h61,8'h51,8'h49,8'h46}, '{8'h21,8'h41,8'h45,8'h4B,8'h31},
        '{8'h18,8'h14,8'h12,8'h7F,8'h10}, '{8'h27,8'h45,8'h45,8'h45,8'h39},
        '{8'h3C,8'h4A,8'h49,8'h49,8'h30}, '{8'h01,8'h71,8'h09,8'h05,8'h03},
        '{8'h36,8'h49,8'h49,8'h49,8'h36}, '{8'h06,8'h49,8'h49,8'h29,8'h1E},
        '{8'h00,8'h36,8'h36,8'h00,8'h00}, '{8'h00,8'h56,8'h36,8'h00,8'h00},
        '{8'h08,8'h14,8'h22,8'h41,8'h00}, '{8'h14,8'h14,8'h14,8'h14,8'h14},
        '{8'h00,8'h41,8'h22,8'h14,8'h08}, '{8'h02,8'h01,8'h51,8'h09,8'h06},
        '{8'h32,8'h49,8'h79,8'h41,8'h3E}, '{8'h7E,8'h11,8'h11,8'h11,8'h7E},
        '{8'h7F,8'h49,8'h49,8'h49,8'h36}, '{8'h3E,8'h41,8'h41,8'h41,8'h22},
        '{8'h7F,8'h41,8'h41,8'h22,8'h1C}, '{8'h7F,8'h49,8'h49,8'h49,8'h41},
        '{8'h7F,8'h09,8'h09,8'h09,8'h01}, '{8'h3E,8'h41,8'h49,8'h49,8'h7A},
        '{8'h7F,8'h08,8'h08,8'h08,8'h7F}, '{8'h00,8'h41,8'h7F,8'h41,8'h00},
        '{8'h20,8'h40,8'h41,8'h3F,8'h01}, '{8'h7F,8'h08,8'h14,8'h22,8'h41},
        '{8'h7F,8'h40,8'h40,8'h40,8'h40}, '{8'h7F,8'h02,8'h0C,8'h02,8'h7F},
        '{8'h7F,8'h04,8'h08,8'h10,8'h7F}, '{8'h3E,8'h41,8'h41,8'h41,8'h3E},
        '{8'h7F,8'h09,8'h09,8'h09,8'h06}, '{8'h3E,8'h41,8'h51,8'h21,8'h5E},
        '{8'h7F,8'h09,8'h19,8'h29,8'h46}, '{8'h46,8'h49,8'h49,8'h49,8'h31},
        '{8'h01,8'h01,8'h7F,8'h01,8'h01}, '{8'h3F,8'h40,8'h40,8'h40,8'h3F},
        '{8'h1F,8'h20,8'h40,8'h20,8'h1F}, '{8'h3F,8'h40,8'h38,8'h40,8'h3F},
        '{8'h63,8'h14,8'h08,8'h14,8'h63}, '{8'h07,8'h08,8'h70,8'h08,8'h07},
        '{8'h61,8'h51,8'h49,8'h45,8'h43}
    };

    // Map a character code to its glyph; anything without a glyph maps to blank
    function automatic logic [GLYPH_W-1:0] rom_index(input logic [CHAR_W-1:0] code);
        logic [CHAR_W-1:0] c;
        logic [GLYPH_W-1:0] idx;
        c   = code;
        idx = '0;
        if (c >= 8'h61 && c <= 8'h7A) begin
            c = c - 8'd32;
        end
        if (c >= 8'h30 && c <= 8'h39) begin
            idx = GLYPH_W'(c - 8'h30 + 8'd16);
        end else if (c >= 8'h41 && c <= 8'h5A) begin
            idx = GLYPH_W'(c - 8'h41 + 8'd33);
        end else if (c >= 8'h21 && c <= 8'h2F) begin
            idx = GLYPH_W'(c - 8'h21 + 8'd1);
        end else if (c >= 8'h3A && c <= 8'h40) begin
            idx = GLYPH_W'(c - 8'h3A + 8'd26);
        end
        return idx;
    endfunction

endpackage

### sv/ctgs_front.sv
`timescale 1ns / 1ps

module ctgs_front (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [ctgs_pkg::S_TDATA_W-1:0]  s_tdata,
    input  logic                            q_full,
    output logic                            q_push,
    output ctgs_pkg::ctgs_entry_t           q_entry
);
    import ctgs_pkg::*;

    logic [CHAR_W-1:0]  character;
    logic [PAGE_W-1:0]  page;
    logic [LEN_W-1:0]   text_length;
    logic [CLAMP_W-1:0] len_clamped;
    logic [SPAN_W-1:0]  line_width;
    logic [SPAN_W-1:0]  line_origin;
    logic [SPAN_W-1:0]  col_sum;
    logic [POS_W-1:0]   pos_used;
    logic [CLAMP_W-1:0] pos_inc;
    logic [POS_W-1:0]   pos_reg;
    logic [POS_W-1:0]   pos_next;

    assign character   = s_tdata[CHAR_W-1:0];
    assign page        = s_tdata[CHAR_W +: PAGE_W];
    assign text_length = s_tdata[CHAR_W+PAGE_W +: LEN_W];

    assign s_tready = !q_full;
    assign q_push   = s_tvalid && !q_full;

    always_comb begin
        if (text_length == '0) begin
            len_clamped = CLAMP_W'(1);
        end else if (CLAMP_W'(text_length) > CLAMP_W'(MAX_TEXT_LENGTH)) begin
            len_clamped = CLAMP_W'(MAX_TEXT_LENGTH);
        end else begin
            len_clamped = CLAMP_W'(text_length);
        end
    end

    always_comb begin
        line_width = SPAN_W'(len_clamped) * SPAN_W'(CHAR_PITCH);
        if (line_width > SPAN_W'(DISPLAY_COLUMNS)) begin
            line_origin = '0;
        end else begin
            line_origin = (SPAN_W'(DISPLAY_COLUMNS) - line_width) >> 1;
        end
    end

    always_comb begin
        // A stale position from a length change restarts the line
        pos_used = (CLAMP_W'(pos_reg) >= len_clamped) ? '0 : pos_reg;
        pos_inc  = CLAMP_W'(pos_used) + CLAMP_W'(1);
        pos_next = (pos_inc >= len_clamped) ? '0 : pos_inc[POS_W-1:0];
        col_sum  = line_origin + SPAN_W'(pos_used) * SPAN_W'(CHAR_PITCH);
    end

    always_comb begin
        q_entry.page   = page;
        q_entry.column = col_sum[BYTE_W-1:0];
        q_entry.glyph  = rom_index(character);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg <= '0;
        end else if (q_push) begin
            pos_reg <= pos_next;
        end
    end

endmodule

### sv/ctgs_queue.sv
`timescale 1ns / 1ps

module ctgs_queue (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  push,
    input  ctgs_pkg::ctgs_entry_t push_entry,
    output logic                  full,
    input  logic                  pop,
    output logic                  head_valid,
    output ctgs_pkg::ctgs_entry_t head_entry
);
    import ctgs_pkg::*;

    ctgs_entry_t        slots [0:QUEUE_DEPTH-1];
    logic [QPTR_W-1:0]  wr_ptr_reg;
    logic [QPTR_W-1:0]  rd_ptr_reg;
    logic [QCNT_W-1:0]  count_reg;

    assign full       = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_entry = slots[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (push) begin
            slots[wr_ptr_reg] <= push_entry;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + QPTR_W'(1);
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + QPTR_W'(1);
            end
            if (push && !pop) begin
                count_reg <= count_reg + QCNT_W'(1);
            end else if (pop && !push) begin
                count_reg <= count_reg - QCNT_W'(1);
            end
        end
    end

endmodule

### sv/ctgs_back.sv
`timescale 1ns / 1ps

module ctgs_back (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            head_valid,
    input  ctgs_pkg::ctgs_entry_t           head_entry,
    output logic                            pop,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [ctgs_pkg::M_TDATA_W-1:0]  m_tdata,
    output logic                            m_tuser,
    output logic                            m_tlast
);
    import ctgs_pkg::*;

    logic [SLOT_W-1:0] slot_reg;
    logic [SLOT_W-1:0] slot_next;
    logic              valid_reg;
    logic [BYTE_W-1:0] byte_reg;
    logic [BYTE_W-1:0] byte_next;
    logic              data_reg;
    logic              data_next;
    logic              last_reg;
    logic              last_next;
    logic              load;
    logic [2:0]        glyph_col;

    assign load = head_valid && (!valid_reg || m_tready);
    assign pop  = load && (slot_reg == SLOT_SPACER);

    always_comb begin
        glyph_col = 3'(slot_reg - SLOT_GLYPH0);
        byte_next = BLANK_COL;
        data_next = 1'b1;
        last_next = 1'b0;
        slot_next = slot_reg + SLOT_W'(1);
        case (slot_reg)
            SLOT_PAGE: begin
                byte_next = CMD_PAGE | BYTE_W'(head_entry.page);
                data_next = 1'b0;
            end
            SLOT_COL_LO: begin
                byte_next = CMD_COL_LO | {4'h0, head_entry.column[3:0]};
                data_next = 1'b0;
            end
            SLOT_COL_HI: begin
                byte_next = CMD_COL_HI | {4'h0, head_entry.column[7:4]};
                data_next = 1'b0;
            end
            SLOT_SPACER: begin
                byte_next = BLANK_COL;
                last_next = 1'b1;
                slot_next = SLOT_PAGE;
            end
            default: begin
                byte_next = FONT_ROM[head_entry.glyph][glyph_col];
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            slot_reg  <= SLOT_PAGE;
            valid_reg <= 1'b0;
        end else if (load) begin
            slot_reg  <= slot_next;
            valid_reg <= 1'b1;
        end else if (m_tready) begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            byte_reg <= byte_next;
            data_reg <= data_next;
            last_reg <= last_next;
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = byte_reg;
    assign m_tuser  = data_reg;
    assign m_tlast  = last_reg;

endmodule

### sv/centered_text_glyph_stream.sv
`timescale 1ns / 1ps

// Centered text renderer for a page-addressed monochrome display.
// Slave channel: one transaction per character of a text line. All characters
// of a line carry the same page and text_length; lengths outside 1..21 clamp.
// Master channel: nine byte transactions per character, in order: page command,
// low column nibble command, high column nibble command (tuser 0), five glyph
// column bytes and one blank spacer column (tuser 1). tlast marks the spacer.
// Each character is written into the queue; its first byte is registered in the
// output register once the character reaches the queue head. The master side
// streams one byte per cycle while tready stays high, from the byte serializer
// in the back end; a two-entry queue lets the next characters be taken while the current one is still going out.
// A stalled master holds its byte and the serializer; the slave side stops
// taking characters once the queue is full.
// Reset empties the queue and output register and restarts the line position
// at the first character.
// Column of a character: (128 - 6*length)/2 + 6*position.
module centered_text_glyph_stream (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,    // character[7:0], page[11:8], text_length[16:12]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,    // byte_value[7:0]
    output logic        m_tuser,    // is_data[0]
    output logic        m_tlast
);
    import ctgs_pkg::*;

    logic        q_full;
    logic        q_push;
    ctgs_entry_t q_entry;
    logic        q_pop;
    logic        head_valid;
    ctgs_entry_t head_entry;

    ctgs_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .q_full   (q_full),
        .q_push   (q_push),
        .q_entry  (q_entry)
    );

    ctgs_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (q_push),
        .push_entry (q_entry),
        .full       (q_full),
        .pop        (q_pop),
        .head_valid (head_valid),
        .head_entry (head_entry)
    );

    ctgs_back u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .head_valid (head_valid),
        .head_entry (head_entry),
        .pop        (q_pop),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser),
        .m_tlast    (m_tlast)
    );

`ifndef SYNTHESIS
    a_last_is_blank_data: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tlast |-> m_tuser && (m_tdata == BLANK_COL))
        else $error("final byte is not a blank data column");

    a_cmd_encoding: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser |-> (m_tdata[7:4] == 4'hB) || (m_tdata[7:4] == 4'h0)
                                 || (m_tdata[7:4] == 4'h1))
        else $error("command byte outside page and column commands");

    a_page_follows_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tready && m_tlast ##1 m_tvalid |-> !m_tuser && (m_tdata[7:4] == 4'hB))
        else $error("character does not start with a page command");
`endif

endmodule

### dv/tb_centered_text_glyph_stream.sv
`timescale 1ns / 1ps

module tb_centered_text_glyph_stream;

    import ctgs_pkg::*;

    localparam logic [7:0] PAGE_CMD   = 8'hB0;
    localparam logic [7:0] COL_LO_CMD = 8'h00;
    localparam logic [7:0] COL_HI_CMD = 8'h10;
    localparam logic [7:0] SPACER     = 8'h00;

    localparam int DIRECTED_ROWS  = 20;
    localparam int TOTAL_CHARS    = 180;
    localparam int REPORT_LIMIT   = 10;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int DRAIN_CYCLES   = 40;

    localparam int LINE_WHOLE  = 0;
    localparam int LINE_BROKEN = 1;
    localparam int LINE_NOISE  = 2;

    localparam logic [1:0] RDY_ALWAYS   = 2'd0;
    localparam logic [1:0] RDY_COIN     = 2'd1;
    localparam logic [1:0] RDY_EVERY4   = 2'd2;
    localparam logic [1:0] RDY_STARVED  = 2'd3;

    typedef struct packed {
        logic       is_data;
        logic [7:0] value;
        logic       last;
    } disp_byte_t;

    typedef struct packed {
        logic [7:0]  code;
        logic [3:0]  page;
        logic [4:0]  len;
        logic        fixed;
        logic [7:0]  col;
        logic [39:0] glyph;
    } char_row_t;

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [23:0] s_tdata  = '0;    // character[7:0], page[11:8], text_length[16:12]
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [7:0]  m_tdata;          // byte_value[7:0]
    logic        m_tuser;          // is_data[0]
    logic        m_tlast;

    disp_byte_t  pending_disp_bytes [$];
    char_row_t   char_table [0:DIRECTED_ROWS-1];
    logic [4:0]  line_pos = '0;
    int          mismatches = 0;
    int          burst_left = 0;
    int          idle_cycles = 0;
    logic [5:0]  ready_phase = '0;
    logic [1:0]  ready_mode = RDY_ALWAYS;

    centered_text_glyph_stream dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    always #5 aclk = ~aclk;

    // Five glyph columns, first column in the top byte
    function automatic logic [39:0] glyph_bits(input logic [5:0] slot);
        case (slot)
            6'd1:  return 40'h00005F0000;  6'd2:  return 40'h0007000700;
            6'd3:  return 40'h147F147F14;  6'd4:  return 40'h242A7F2A12;
            6'd5:  return 40'h2313086462;  6'd6:  return 40'h3649552250;
            6'd7:  return 40'h0005030000;  6'd8:  return 40'h001C224100;
            6'd9:  return 40'h0041221C00;  6'd10: return 40'h14083E0814;
            6'd11: return 40'h08083E0808;  6'd12: return 40'h0050300000;
            6'd13: return 40'h0808080808;  6'd14: return 40'h0060600000;
            6'd15: return 40'h2010080402;  6'd16: return 40'h3E5149453E;
            6'd17: return 40'h00427F4000;  6'd18: return 40'h4261514946;
            6'd19: return 40'h2141454B31;  6'd20: return 40'h1814127F10;
            6'd21: return 40'h2745454539;  6'd22: return 40'h3C4A494930;
            6'd23: return 40'h0171090503;  6'd24: return 40'h3649494936;
            6'd25: return 40'h064949291E;  6'd26: return 40'h0036360000;
            6'd27: return 40'h0056360000;  6'd28: return 40'h0814224100;
            6'd29: return 40'h1414141414;  6'd30: return 40'h0041221408;
            6'd31: return 40'h0201510906;  6'd32: return 40'h324979413E;
            6'd33: return 40'h7E1111117E;  6'd34: return 40'h7F49494936;
            6'd35: return 40'h3E41414122;  6'd36: return 40'h7F4141221C;
            6'd37: return 40'h7F49494941;  6'd38: return 40'h7F09090901;
            6'd39: return 40'h3E4149497A;  6'd40: return 40'h7F0808087F;
            6'd41: return 40'h00417F4100;  6'd42: return 40'h2040413F01;
            6'd43: return 40'h7F08142241;  6'd44: return 40'h7F40404040;
            6'd45: return 40'h7F020C027F;  6'd46: return 40'h7F0408107F;
            6'd47: return 40'h3E4141413E;  6'd48: return 40'h7F09090906;
            6'd49: return 40'h3E4151215E;  6'd50: return 40'h7F09192946;
            6'd51: return 40'h4649494931;  6'd52: return 40'h01017F0101;
            6'd53: return 40'h3F4040403F;  6'd54: return 40'h1F2040201F;
            6'd55: return 40'h3F4038403F;  6'd56: return 40'h6314081463;
            6'd57: return 40'h0708700807;  6'd58: return 40'h6151494543;
            default: return 40'h0000000000;
        endcase
    endfunction

    // Control codes, codes from 127 up and unlisted symbols fall through to blank
    function automatic logic [5:0] glyph_slot(input logic [7:0] code);
        logic [7:0] c;
        c = code;
        if (c >= 8'h61 && c <= 8'h7A) c = c - 8'h20;
        if (c >= 8'h21 && c <= 8'h2F) return 6'(c - 8'h21 + 8'd1);
        if (c >= 8'h30 && c <= 8'h39) return 6'(c - 8'h30 + 8'd16);
        if (c >= 8'h3A && c <= 8'h40) return 6'(c - 8'h3A + 8'd26);
        if (c >= 8'h41 && c <= 8'h5A) return 6'(c - 8'h41 + 8'd33);
        return 6'd0;
    endfunction

    // Column of the next character; advance the line position
    task automatic place_char(input logic [7:0] code, input logic [4:0] len,
                              output logic [7:0] col, output logic [39:0] glyph);
        int eff;
        int span;
        int start;
        int pos;
        eff = (len == 0) ? 1 : (len > MAX_TEXT_LENGTH) ? MAX_TEXT_LENGTH : int'(len);
        span = CHAR_PITCH * eff;
        start = (span > DISPLAY_COLUMNS) ? 0 : (DISPLAY_COLUMNS - span) / 2;
        pos = (int'(line_pos) >= eff) ? 0 : int'(line_pos);
        col = 8'((start + pos * CHAR_PITCH) & 255);
        line_pos = (pos + 1 >= eff) ? 5'd0 : 5'(pos + 1);
        glyph = glyph_bits(glyph_slot(code));
    endtask

    task automatic push_disp_bytes(input logic [3:0] page, input logic [7:0] col,
                                   input logic [39:0] glyph);
        pending_disp_bytes.push_back('{1'b0, PAGE_CMD | {4'h0, page}, 1'b0});
        pending_disp_bytes.push_back('{1'b0, COL_LO_CMD | {4'h0, col[3:0]}, 1'b0});
        pending_disp_bytes.push_back('{1'b0, COL_HI_CMD | {4'h0, col[7:4]}, 1'b0});
        for (int k = 0; k < 5; k++)
            pending_disp_bytes.push_back('{1'b1, glyph[39 - 8 * k -: 8], 1'b0});
        pending_disp_bytes.push_back('{1'b1, SPACER, 1'b1});
    endtask

    // Send one character in bursts; a fixed row overrides the predicted column and glyph
    task automatic send_char(input logic [7:0] code, input logic [3:0] page,
                             input logic [4:0] len, input logic fixed,
                             input logic [7:0] f_col, input logic [39:0] f_glyph);
        int gap;
        logic [7:0] col;
        logic [39:0] glyph;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 12);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 15);
            if (gap != 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end
        burst_left--;
        s_tvalid <= 1'b1;
        s_tdata <= {7'd0, len, page, code};
        do @(posedge aclk); while (!s_tready);
        place_char(code, len, col, glyph);
        if (fixed) begin
            col = f_col;
            glyph = f_glyph;
        end
        push_disp_bytes(page, col, glyph);
    endtask

    // Receiver stall pattern: pick a new mode each time the phase counter wraps
    always @(posedge aclk) begin
        ready_phase <= ready_phase + 6'd1;
        if (ready_phase == 6'd0) ready_mode <= 2'($urandom_range(0, 3));
        case (ready_mode)
            RDY_ALWAYS:  m_tready <= 1'b1;
            RDY_COIN:    m_tready <= 1'($urandom_range(0, 1));
            RDY_EVERY4:  m_tready <= (ready_phase[1:0] == 2'b11);
            RDY_STARVED: m_tready <= ($urandom_range(0, 9) == 0);
            default:     m_tready <= 1'b1;
        endcase
    end

    always @(posedge aclk) begin
        disp_byte_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_disp_bytes.size() == 0) begin
                mismatches++;
                if (mismatches <= REPORT_LIMIT)
                    $display("unexpected byte: tuser=%0d tdata=%02h tlast=%0d",
                             m_tuser, m_tdata, m_tlast);
            end else begin
                want = pending_disp_bytes.pop_front();
                if (m_tuser !== want.is_data || m_tdata !== want.value ||
                    m_tlast !== want.last) begin
                    mismatches++;
                    if (mismatches <= REPORT_LIMIT)
                        $display("byte mismatch: expected tuser=%0d tdata=%02h tlast=%0d, %s",
                                 want.is_data, want.value, want.last,
                                 $sformatf("got tuser=%0d tdata=%02h tlast=%0d",
                                           m_tuser, m_tdata, m_tlast));
                end
            end
        end
    end

    // Drop the run when nothing moves for too long
    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles == WATCHDOG_LIMIT) begin
            $display("tb: failure");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        int items_sent;
        int count;
        int roll;
        int line_kind;
        int eff_len;
        logic [7:0] code;
        logic [3:0] page;
        logic [4:0] len_field;

        char_table = '{
            // reset position, single-character line, fold to uppercase
            '{8'h41, 4'h0, 5'd1,  1'b1, 8'h3D, 40'h7E1111117E},
            '{8'h61, 4'hF, 5'd1,  1'b1, 8'h3D, 40'h7E1111117E},
            // zero length counts as one, control code is blank
            '{8'h00, 4'h5, 5'd0,  1'b1, 8'h3D, 40'h0000000000},
            // overlong length clamps; high codes and '~' and DEL are blank
            '{8'hFF, 4'hA, 5'd31, 1'b1, 8'h01, 40'h0000000000},
            '{8'h7E, 4'hA, 5'd21, 1'b1, 8'h07, 40'h0000000000},
            '{8'h7F, 4'hA, 5'd21, 1'b1, 8'h0D, 40'h0000000000},
            // length shrinks mid-line: stale position restarts at zero
            '{8'h30, 4'h3, 5'd2,  1'b1, 8'h3A, 40'h3E5149453E},
            '{8'h39, 4'h3, 5'd2,  1'b1, 8'h40, 40'h064949291E},
            '{8'h21, 4'h7, 5'd21, 1'b0, 8'h00, 40'h0},
            '{8'h2F, 4'h7, 5'd21, 1'b0, 8'h00, 40'h0},
            '{8'h3A, 4'h7, 5'd21, 1'b0, 8'h00, 40'h0},
            '{8'h40, 4'h7, 5'd21, 1'b0, 8'h00, 40'h0},
            '{8'h5B, 4'h7, 5'd22, 1'b0, 8'h00, 40'h0},
            '{8'h60, 4'h7, 5'd21, 1'b0, 8'h00, 40'h0},
            '{8'h7A, 4'h7, 5'd21, 1'b0, 8'h00, 40'h0},
            '{8'h7B, 4'h7, 5'd21, 1'b0, 8'h00, 40'h0},
            '{8'h20, 4'h8, 5'd21, 1'b0, 8'h00, 40'h0},
            '{8'h1F, 4'h8, 5'd21, 1'b0, 8'h00, 40'h0},
            '{8'h80, 4'h8, 5'd21, 1'b0, 8'h00, 40'h0},
            '{8'h5A, 4'h8, 5'd21, 1'b0, 8'h00, 40'h0}
        };

        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        for (int r = 0; r < DIRECTED_ROWS; r++)
            send_char(char_table[r].code, char_table[r].page, char_table[r].len,
                      char_table[r].fixed, char_table[r].col, char_table[r].glyph);
        items_sent = DIRECTED_ROWS;

        // Mostly whole lines with random text; some cut short, some noise
        while (items_sent < TOTAL_CHARS) begin
            roll = $urandom_range(0, 9);
            line_kind = (roll < 7) ? LINE_WHOLE : (roll < 9) ? LINE_BROKEN : LINE_NOISE;
            page = 4'($urandom_range(0, 15));
            eff_len = ($urandom_range(0, 2) == 0) ? $urandom_range(1, 4)
                                                  : $urandom_range(1, MAX_TEXT_LENGTH);
            len_field = 5'(eff_len);
            if (eff_len == MAX_TEXT_LENGTH && $urandom_range(0, 1) == 1)
                len_field = 5'($urandom_range(MAX_TEXT_LENGTH + 1, 31));
            if (eff_len == 1 && $urandom_range(0, 1) == 1)
                len_field = 5'd0;
            count = eff_len;
            if (line_kind == LINE_BROKEN && eff_len > 1)
                count = $urandom_range(1, eff_len - 1);
            if (line_kind == LINE_NOISE)
                count = $urandom_range(1, 4);
            for (int k = 0; k < count; k++) begin
                code = ($urandom_range(0, 4) == 0) ? 8'($urandom_range(0, 255))
                                                   : 8'($urandom_range(32, 127));
                if (line_kind == LINE_NOISE)
                    len_field = 5'($urandom_range(0, 31));
                send_char(code, page, len_field, 1'b0, 8'h00, 40'h0);
                items_sent++;
            end
        end
        s_tvalid <= 1'b0;

        while (pending_disp_bytes.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        if (mismatches == 0 && pending_disp_bytes.size() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

### sim.f
sv/ctgs_pkg.sv
sv/ctgs_front.sv
sv/ctgs_queue.sv
sv/ctgs_back.sv
sv/centered_text_glyph_stream.sv
dv/tb_centered_text_glyph_stream.sv
